/* src/b2a_pkg.sv */
// Package: shared constants for the binary to ASCII converter.
package b2a_pkg;

  localparam int ValueW    = 32;
  localparam int CharW     = 8;
  localparam int NibW      = 4;
  localparam int DecDigits = 10;
  localparam int HexDigits = 8;
  localparam int BcdW      = DecDigits * NibW;
  localparam int CntW      = $clog2(ValueW);
  localparam int RemW      = $clog2(DecDigits + 1);

  localparam logic           CmdDec        = 1'b0;
  localparam logic           CmdHex        = 1'b1;
  localparam logic [CharW-1:0] AsciiZero     = 8'd48;
  localparam logic [CharW-1:0] AsciiX        = 8'h78;
  localparam logic [CharW-1:0] AsciiAlphaOff = 8'd55;
  localparam logic [NibW-1:0]  NibTen        = 4'd10;

endpackage

/* src/b2a_if.sv */
// Interfaces: request channel (format and value) and character channel.
interface b2a_in_if;
  import b2a_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ValueW-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface b2a_out_if;
  import b2a_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

/* src/b2a_conv.sv */
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module b2a_conv import b2a_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ValueW-1:0] value_i,
  output logic              done_o,
  output logic [BcdW-1:0]   bcd_o
);

  logic [ValueW-1:0] sh_q, sh_d;
  logic [BcdW-1:0]   bcd_q, bcd_d, bcd_adj;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      if (bcd_q[i*NibW +: NibW] > 4'd4) begin
        bcd_adj[i*NibW +: NibW] = bcd_q[i*NibW +: NibW] + 4'd3;
      end else begin
        bcd_adj[i*NibW +: NibW] = bcd_q[i*NibW +: NibW];
      end
    end
  end

  always_comb begin
    sh_d   = sh_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = value_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[BcdW-2:0], sh_q[ValueW-1]};
      sh_d  = {sh_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(ValueW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

/* src/binary_to_ascii_decimal_hex.sv */
// Top level: formats a 32-bit unsigned value as decimal or 0x-prefixed hex ASCII text.
//
// in_i carries one request: cmd (0 decimal, 1 hex) and a 32-bit value.
// out_o returns the text one character per transfer, most significant first,
// with last set on the final character. Decimal has no leading zeros (zero
// gives "0"); hex is always "0x" plus eight upper-case digits.
// One request is worked on at a time; in_i.ready is high while idle.
// Hex: the request goes straight to the character sequencer, which emits "0x"
// and then one character per cycle while the receiver is ready.
// Decimal: the value goes bit-serially through the BCD converter, leading
// zero digits are then dropped one at a time, and the rest follow at one
// character per cycle while the receiver is ready. No new request is taken
// until the final character has been loaded into the output register.
// The last character sits in the output register while the next request is
// already taken. A stalled receiver holds the output register and the
// character sequencer waits; nothing is lost.
// Reset clears the sequencer and the output valid; no request is pending.
module binary_to_ascii_decimal_hex import b2a_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  b2a_in_if.sink      in_i,
  b2a_out_if.source   out_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StSkip = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [BcdW-1:0]  digits_q, digits_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [1:0]       pre_q, pre_d;
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;

  logic             in_fire, slot_free, conv_done;
  logic [BcdW-1:0]  conv_bcd;
  logic [NibW-1:0]  nib;
  logic [CharW-1:0] digit_char;

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;

  b2a_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire && (in_i.cmd == CmdDec)),
    .value_i (in_i.value),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  assign nib        = digits_q[BcdW-1 -: NibW];
  assign digit_char = (nib < NibTen) ? (AsciiZero + {4'b0, nib})
                                     : (AsciiAlphaOff + {4'b0, nib});

  always_comb begin
    state_d     = state_q;
    digits_d    = digits_q;
    rem_d       = rem_q;
    pre_d       = pre_q;
    out_valid_d = out_valid_q && !out_o.ready;
    char_d      = char_q;
    last_d      = last_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (in_i.cmd == CmdHex) begin
            digits_d = {in_i.value, {(BcdW-ValueW){1'b0}}};
            rem_d    = RemW'(HexDigits);
            pre_d    = 2'd2;
            state_d  = StEmit;
          end else begin
            state_d = StConv;
          end
        end
      end
      StConv: begin
        if (conv_done) begin
          digits_d = conv_bcd;
          rem_d    = RemW'(DecDigits);
          pre_d    = 2'd0;
          state_d  = StSkip;
        end
      end
      StSkip: begin
        if (nib == '0 && rem_q != RemW'(1)) begin
          digits_d = {digits_q[BcdW-NibW-1:0], {NibW{1'b0}}};
          rem_d    = rem_q - 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (pre_q != 2'd0) begin
            char_d = (pre_q == 2'd2) ? AsciiZero : AsciiX;
            last_d = 1'b0;
            pre_d  = pre_q - 1'b1;
          end else begin
            char_d   = digit_char;
            last_d   = (rem_q == RemW'(1));
            digits_d = {digits_q[BcdW-NibW-1:0], {NibW{1'b0}}};
            rem_d    = rem_q - 1'b1;
            if (rem_q == RemW'(1)) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rem_q       <= '0;
      pre_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      pre_q       <= pre_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    char_q   <= char_d;
    last_q   <= last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.last      = last_q;

  a_conv_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> state_q == StConv)
    else $error("converter finished outside conversion");

  a_emit_has_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> rem_q != '0)
    else $error("emitting with no characters left");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != StIdle)
    else $error("request accepted but sequencer stayed idle");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit && slot_free && pre_q == 2'd0 && rem_q == RemW'(1)
      |=> out_valid_q && last_q && state_q == StIdle)
    else $error("final character not marked last");

endmodule
